[rtl/core/flptw_pkg.sv]
// Shared constants, codes and word types of the four-level page table walker.
package flptw_pkg;

  localparam int unsigned TABLE_PAGES = 64;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned ENTRIES     = 1 << IDX_W;
  localparam int unsigned PAGE_W      = $clog2(TABLE_PAGES);
  localparam int unsigned NEXT_W      = $clog2(TABLE_PAGES + 1);
  localparam int unsigned DEPTH       = TABLE_PAGES * ENTRIES;
  localparam int unsigned ADDR_W      = PAGE_W + IDX_W;
  localparam int unsigned ENTRY_LAST  = DEPTH - 1;
  localparam int unsigned PA_W        = 52;
  localparam int unsigned VA_W        = 48;
  localparam int unsigned FLAGS_W     = 12;
  localparam int unsigned PFN_W       = PA_W - 12;
  localparam int unsigned ENTRY_W     = 64;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_LARGE   = 7;

  // Walk levels, counted down from the root table.
  localparam logic [1:0] LVL_ROOT = 2'd3;
  localparam logic [1:0] LVL_1G   = 2'd2;
  localparam logic [1:0] LVL_2M   = 2'd1;
  localparam logic [1:0] LVL_4K   = 2'd0;

  typedef enum logic [1:0] {
    CMD_MAP       = 2'd0,
    CMD_UNMAP     = 2'd1,
    CMD_TRANSLATE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_MISSING = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_LARGE   = 3'd3,
    STAT_BADREF  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    WS_INIT,
    WS_IDLE,
    WS_READ,
    WS_EVAL,
    WS_CLEAR,
    WS_LINK,
    WS_DONE
  } walk_state_e;

  typedef struct packed {
    logic [FLAGS_W-1:0] page_flags;
    logic [PA_W-1:0]    map_addr;
    logic [VA_W-1:0]    lookup_addr;
    logic [1:0]         command;
  } walk_req_t;

  typedef struct packed {
    status_e         status;
    logic [PA_W-1:0] result_addr;
  } walk_rsp_t;

endpackage

[rtl/core/four_level_page_table_walker_core.sv]
// Top level of the four-level page table walker: config register, walker and result buffer.
//
// Usage: commands (map, unmap, translate) enter on the s_axis channel, one word per
// command, and each gives exactly one result word on the m_axis channel. The base of
// the table pool is written on the cfg channel, which is always ready; write it only
// while no command is in flight.
// After reset the block runs a clearing pass over the whole table store, one entry per
// cycle (TABLE_PAGES*512 entries, 32768 at 64 pages); s_axis_tready_o stays low until
// it ends. Page allocation restarts at pool page one.
// Walk: each level is a store read (WS_READ) followed by an evaluation (WS_EVAL). A map
// that creates a table first clears its 512 entries (WS_CLEAR) and then writes the link
// (WS_LINK); a walk that stops early or places a large leaf skips the levels below, and
// an unknown command goes straight to WS_DONE. Once its result is taken into the buffer
// the walker returns to WS_IDLE and accepts again. The table store has a single read
// port and every level depends on the entry read at the level above, so a walk cannot
// overlap the next. One command is walked at a time.
// Stall: a finished result waits in the output buffer; the walker meanwhile takes the
// next command and holds its own result until the buffer frees up.
module four_level_page_table_walker_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config write channel: table_base[51:0]
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [51:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata: lookup address[47:0], map address[99:48], page_flags[111:100]
  input  logic [111:0]  s_axis_tdata_i,
  // tuser: command[1:0]
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata: result_addr[51:0], status[54:52], zero pad [55]
  output logic [55:0]   m_axis_tdata_o
);

  logic [flptw_pkg::PA_W-1:0] table_base_q;
  flptw_pkg::walk_req_t       req;
  flptw_pkg::walk_rsp_t       rsp;
  logic                       rsp_valid, rsp_ready;
  logic                       out_valid_q;
  flptw_pkg::walk_rsp_t       out_q;

  // Unpack the command word.
  assign req.command     = s_axis_tuser_i;
  assign req.lookup_addr = s_axis_tdata_i[47:0];
  assign req.map_addr    = s_axis_tdata_i[99:48];
  assign req.page_flags  = s_axis_tdata_i[111:100];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
    end else if (cfg_valid_i) begin
      table_base_q <= cfg_data_i;
    end
  end

  flptw_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .table_base_i (table_base_q),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_o  (s_axis_tready_o),
    .req_i        (req),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_o        (rsp)
  );

  // Load the buffer when it is empty or draining this cycle.
  assign rsp_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

endmodule

[rtl/core/flptw_store.sv]
// Table store: one write port and one registered read port.
module flptw_store (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [flptw_pkg::ADDR_W-1:0]        waddr_i,
  input  logic [flptw_pkg::ENTRY_W-1:0]       wdata_i,
  input  logic                                re_i,
  input  logic [flptw_pkg::ADDR_W-1:0]        raddr_i,
  output logic [flptw_pkg::ENTRY_W-1:0]       rdata_o
);

  logic [flptw_pkg::ENTRY_W-1:0] mem [flptw_pkg::DEPTH];
  logic [flptw_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/flptw_walk.sv]
// Walk sequencer: reads, follows, creates and writes table entries one level at a time.
module flptw_walk (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [flptw_pkg::PA_W-1:0]          table_base_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  flptw_pkg::walk_req_t                req_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output flptw_pkg::walk_rsp_t                rsp_o
);

  flptw_pkg::walk_state_e state_q, state_d;

  logic [1:0]                       cmd_q, cmd_d;
  logic [flptw_pkg::VA_W-1:0]       va_q, va_d;
  logic [flptw_pkg::PA_W-1:0]       pa_q, pa_d;
  logic [flptw_pkg::FLAGS_W-1:0]    flags_q, flags_d;
  logic [1:0]                       level_q, level_d;
  logic [flptw_pkg::PAGE_W-1:0]     page_q, page_d;
  logic [flptw_pkg::PAGE_W-1:0]     child_q, child_d;
  logic [flptw_pkg::NEXT_W-1:0]     next_page_q, next_page_d;
  logic [flptw_pkg::ADDR_W-1:0]     clr_q, clr_d;
  logic [flptw_pkg::PA_W-1:0]       res_q, res_d;
  flptw_pkg::status_e               st_q, st_d;

  logic                             mem_we, mem_re;
  logic [flptw_pkg::ADDR_W-1:0]     mem_waddr;
  logic [flptw_pkg::ENTRY_W-1:0]    mem_wdata;
  logic [flptw_pkg::ENTRY_W-1:0]    mem_rdata;

  logic [flptw_pkg::IDX_W-1:0]      cur_idx;
  logic [flptw_pkg::ADDR_W-1:0]     slot_addr;
  logic                             is_map, is_unmap, is_xlate;
  logic                             req_large;
  logic                             map_leaf_here, unmap_leaf_here;
  logic                             e_present, e_large;
  logic [flptw_pkg::PFN_W-1:0]      base_pfn, e_pfn, diff_pfn, link_pfn;
  logic                             bad_ref, pool_full;
  logic                             xlate_leaf, xlate_large_hit;
  logic                             accept;
  logic                             init_last, clr_last;

  flptw_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot_addr),
    .rdata_o (mem_rdata)
  );

  // Decode of the current step.
  always_comb begin
    case (level_q)
      flptw_pkg::LVL_ROOT: cur_idx = va_q[47:39];
      flptw_pkg::LVL_1G:   cur_idx = va_q[38:30];
      flptw_pkg::LVL_2M:   cur_idx = va_q[29:21];
      default:             cur_idx = va_q[20:12];
    endcase
  end

  assign slot_addr = {page_q, cur_idx};
  assign is_map    = (cmd_q == flptw_pkg::CMD_MAP);
  assign is_unmap  = (cmd_q == flptw_pkg::CMD_UNMAP);
  assign is_xlate  = (cmd_q == flptw_pkg::CMD_TRANSLATE);
  assign req_large = flags_q[flptw_pkg::BIT_LARGE];

  // Map places its leaf without reading when the level matches size and alignment.
  assign map_leaf_here = is_map &&
      ((level_q == flptw_pkg::LVL_4K) ||
       ((level_q == flptw_pkg::LVL_1G) && req_large && (pa_q[29:0] == '0)) ||
       ((level_q == flptw_pkg::LVL_2M) && req_large && (pa_q[20:0] == '0)));
  assign unmap_leaf_here = is_unmap && (level_q == flptw_pkg::LVL_4K);

  assign e_present = mem_rdata[flptw_pkg::BIT_PRESENT];
  assign e_large   = mem_rdata[flptw_pkg::BIT_LARGE];
  assign base_pfn  = table_base_i[flptw_pkg::PA_W-1:12];
  assign e_pfn     = mem_rdata[flptw_pkg::PA_W-1:12];
  assign diff_pfn  = e_pfn - base_pfn;
  assign bad_ref   = (e_pfn < base_pfn) ||
                     (diff_pfn >= flptw_pkg::PFN_W'(flptw_pkg::TABLE_PAGES));
  assign link_pfn  = base_pfn + flptw_pkg::PFN_W'(child_q);
  assign pool_full = (next_page_q >= flptw_pkg::NEXT_W'(flptw_pkg::TABLE_PAGES));

  assign xlate_leaf      = is_xlate && (level_q == flptw_pkg::LVL_4K);
  assign xlate_large_hit = is_xlate && e_present && e_large &&
                           ((level_q == flptw_pkg::LVL_1G) || (level_q == flptw_pkg::LVL_2M));

  assign accept    = req_valid_i && req_ready_o;
  assign init_last = (clr_q == flptw_pkg::ADDR_W'(flptw_pkg::ENTRY_LAST));
  assign clr_last  = (clr_q[flptw_pkg::IDX_W-1:0] == flptw_pkg::IDX_W'(flptw_pkg::ENTRIES - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      flptw_pkg::WS_INIT: begin
        if (init_last) state_d = flptw_pkg::WS_IDLE;
      end
      flptw_pkg::WS_IDLE: begin
        if (accept) begin
          if ((req_i.command == flptw_pkg::CMD_MAP) ||
              (req_i.command == flptw_pkg::CMD_UNMAP) ||
              (req_i.command == flptw_pkg::CMD_TRANSLATE)) begin
            state_d = flptw_pkg::WS_READ;
          end else begin
            state_d = flptw_pkg::WS_DONE;
          end
        end
      end
      flptw_pkg::WS_READ: begin
        if (map_leaf_here || unmap_leaf_here) state_d = flptw_pkg::WS_DONE;
        else state_d = flptw_pkg::WS_EVAL;
      end
      flptw_pkg::WS_EVAL: begin
        if (xlate_leaf || xlate_large_hit) begin
          state_d = flptw_pkg::WS_DONE;
        end else if (!e_present) begin
          if (is_map && !pool_full) state_d = flptw_pkg::WS_CLEAR;
          else state_d = flptw_pkg::WS_DONE;
        end else if (e_large || bad_ref) begin
          state_d = flptw_pkg::WS_DONE;
        end else begin
          state_d = flptw_pkg::WS_READ;
        end
      end
      flptw_pkg::WS_CLEAR: begin
        if (clr_last) state_d = flptw_pkg::WS_LINK;
      end
      flptw_pkg::WS_LINK: begin
        state_d = flptw_pkg::WS_READ;
      end
      flptw_pkg::WS_DONE: begin
        if (rsp_ready_i) state_d = flptw_pkg::WS_IDLE;
      end
      default: state_d = flptw_pkg::WS_INIT;
    endcase
  end

  // Walk registers.
  always_comb begin
    cmd_d       = cmd_q;
    va_d        = va_q;
    pa_d        = pa_q;
    flags_d     = flags_q;
    level_d     = level_q;
    page_d      = page_q;
    child_d     = child_q;
    next_page_d = next_page_q;
    clr_d       = clr_q;
    res_d       = res_q;
    st_d        = st_q;
    case (state_q)
      flptw_pkg::WS_INIT: begin
        clr_d = clr_q + flptw_pkg::ADDR_W'(1);
      end
      flptw_pkg::WS_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.command;
          va_d    = req_i.lookup_addr;
          pa_d    = req_i.map_addr;
          flags_d = req_i.page_flags;
          level_d = flptw_pkg::LVL_ROOT;
          page_d  = '0;
          res_d   = '0;
          st_d    = flptw_pkg::STAT_OK;
        end
      end
      flptw_pkg::WS_EVAL: begin
        if (xlate_leaf) begin
          if (e_present) res_d = {mem_rdata[flptw_pkg::PA_W-1:12], va_q[11:0]};
          else st_d = flptw_pkg::STAT_MISSING;
        end else if (xlate_large_hit) begin
          if (level_q == flptw_pkg::LVL_1G) begin
            res_d = {mem_rdata[flptw_pkg::PA_W-1:30], va_q[29:0]};
          end else begin
            res_d = {mem_rdata[flptw_pkg::PA_W-1:21], va_q[20:0]};
          end
        end else if (!e_present) begin
          if (!is_map) begin
            st_d = flptw_pkg::STAT_MISSING;
          end else if (pool_full) begin
            st_d = flptw_pkg::STAT_FULL;
          end else begin
            child_d     = next_page_q[flptw_pkg::PAGE_W-1:0];
            next_page_d = next_page_q + flptw_pkg::NEXT_W'(1);
            clr_d       = '0;
          end
        end else if (e_large) begin
          st_d = flptw_pkg::STAT_LARGE;
        end else if (bad_ref) begin
          st_d = flptw_pkg::STAT_BADREF;
        end else begin
          page_d  = diff_pfn[flptw_pkg::PAGE_W-1:0];
          level_d = level_q - 2'd1;
        end
      end
      flptw_pkg::WS_CLEAR: begin
        clr_d = clr_q + flptw_pkg::ADDR_W'(1);
      end
      flptw_pkg::WS_LINK: begin
        page_d  = child_q;
        level_d = level_q - 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Store port control and handshakes.
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = slot_addr;
    mem_wdata   = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      flptw_pkg::WS_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      flptw_pkg::WS_IDLE: begin
        req_ready_o = 1'b1;
      end
      flptw_pkg::WS_READ: begin
        if (map_leaf_here) begin
          mem_we    = 1'b1;
          mem_wdata = {12'b0, pa_q | {{(flptw_pkg::PA_W - flptw_pkg::FLAGS_W){1'b0}}, flags_q}};
        end else if (unmap_leaf_here) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      flptw_pkg::WS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {child_q, clr_q[flptw_pkg::IDX_W-1:0]};
      end
      flptw_pkg::WS_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {12'b0, link_pfn, 12'h003};
      end
      flptw_pkg::WS_DONE: begin
        rsp_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.status      = st_q;
  assign rsp_o.result_addr = (st_q == flptw_pkg::STAT_OK) ? res_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flptw_pkg::WS_INIT;
      next_page_q <= flptw_pkg::NEXT_W'(1);
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      next_page_q <= next_page_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    va_q    <= va_d;
    pa_q    <= pa_d;
    flags_q <= flags_d;
    level_q <= level_d;
    page_q  <= page_d;
    child_q <= child_d;
    res_q   <= res_d;
    st_q    <= st_d;
  end

endmodule

[test/four_level_page_table_walker_core_tb.sv]
// Self-checking testbench for the four-level page table walker core.
module four_level_page_table_walker_core_tb;
  import flptw_pkg::*;

  localparam bit [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
  localparam bit [63:0] MASK52     = 64'h000F_FFFF_FFFF_FFFF;
  localparam bit [63:0] OFF_1G     = 64'h0000_0000_3FFF_FFFF;
  localparam bit [63:0] OFF_2M     = 64'h0000_0000_001F_FFFF;
  localparam bit [63:0] OFF_4K     = 64'h0000_0000_0000_0FFF;
  localparam bit [63:0] LINK_FLAGS = 64'h3;  // present and writable
  localparam bit [51:0] BASE_TOP   = 52'hF_FFFF_FFFF_F000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_LOGGED  = 40;

  typedef struct {
    logic [1:0] cmd;
    bit [47:0]  va;
    bit [51:0]  pa;
    bit [11:0]  flags;
  } walk_cmd_t;

  typedef struct {
    bit [51:0] addr;
    status_e   status;
  } walk_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [51:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic [111:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic m_ready = 1'b0;
  logic cfg_ready_o, s_axis_tready_o, m_axis_tvalid_o;
  logic [55:0] m_axis_tdata_o;

  // Shadow copy of the walker state.
  bit [63:0]   pt_mem [DEPTH];
  int unsigned next_page = 1;
  bit [51:0]   pool_base = '0;

  walk_cmd_t    pending_cmds[$];
  walk_result_t expected_results[$];

  int unsigned send_idle = 0, recv_idle = 0;
  logic in_taken = 1'b0;
  int unsigned words_queued = 0, words_taken = 0, results_seen = 0;
  int unsigned mismatches = 0, base_settings = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned cmd_seen [4];
  int unsigned outcome_seen [8];

  four_level_page_table_walker_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_LOGGED) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Follow the link at one entry, or create the table it should point to.
  function automatic status_e follow_link(input int unsigned page, input int unsigned idx,
                                          input bit create, output int unsigned child);
    bit [63:0] ent, link, base_al, off;
    int unsigned slot, p, k;
    base_al = {12'd0, pool_base} & ADDR_MASK;
    slot = page * ENTRIES + idx;
    ent = pt_mem[slot];
    child = 0;
    if (!ent[BIT_PRESENT]) begin
      if (!create) return STAT_MISSING;
      if (next_page >= TABLE_PAGES) return STAT_FULL;
      p = next_page;
      next_page++;
      for (k = 0; k < ENTRIES; k++) pt_mem[p * ENTRIES + k] = '0;
      // Link wraps at 52 bits when the base sits near the top.
      pt_mem[slot] = ((base_al + 64'(p) * 64'd4096) & ADDR_MASK) | LINK_FLAGS;
      child = p;
      return STAT_OK;
    end
    if (ent[BIT_LARGE]) return STAT_LARGE;
    link = ent & ADDR_MASK;
    if (link < base_al) return STAT_BADREF;
    off = (link - base_al) >> 12;
    if (off >= TABLE_PAGES) return STAT_BADREF;
    child = int'(off);
    return STAT_OK;
  endfunction

  // Walk one command through the shadow tables and give its result word.
  function automatic void predict_walk(input logic [1:0] cmd, input bit [47:0] va,
                                       input bit [51:0] pa, input bit [11:0] flags,
                                       output bit [51:0] res, output status_e st);
    int unsigned i4, i3, i2, i1, l3, l2, l1;
    bit [63:0] va64, leaf, ent, r64;
    bit big;
    va64 = {16'd0, va};
    leaf = {12'd0, pa} | {52'd0, flags};
    big = flags[BIT_LARGE];
    i4 = 32'(va[47:39]);
    i3 = 32'(va[38:30]);
    i2 = 32'(va[29:21]);
    i1 = 32'(va[20:12]);
    l3 = 0;
    l2 = 0;
    l1 = 0;
    r64 = '0;
    st = STAT_OK;
    case (cmd)
      CMD_MAP: begin
        st = follow_link(0, i4, 1'b1, l3);
        if (st == STAT_OK) begin
          if (big && pa[29:0] == 0) begin
            pt_mem[l3 * ENTRIES + i3] = leaf;
          end else begin
            st = follow_link(l3, i3, 1'b1, l2);
            if (st == STAT_OK) begin
              if (big && pa[20:0] == 0) begin
                pt_mem[l2 * ENTRIES + i2] = leaf;
              end else begin
                st = follow_link(l2, i2, 1'b1, l1);
                if (st == STAT_OK) pt_mem[l1 * ENTRIES + i1] = leaf;
              end
            end
          end
        end
      end
      CMD_UNMAP: begin
        st = follow_link(0, i4, 1'b0, l3);
        if (st == STAT_OK) st = follow_link(l3, i3, 1'b0, l2);
        if (st == STAT_OK) st = follow_link(l2, i2, 1'b0, l1);
        if (st == STAT_OK) pt_mem[l1 * ENTRIES + i1] = '0;
      end
      CMD_TRANSLATE: begin
        st = follow_link(0, i4, 1'b0, l3);
        if (st == STAT_OK) begin
          ent = pt_mem[l3 * ENTRIES + i3];
          if (ent[BIT_PRESENT] && ent[BIT_LARGE]) begin
            r64 = (ent & MASK52 & ~OFF_1G) | (va64 & OFF_1G);
          end else begin
            st = follow_link(l3, i3, 1'b0, l2);
            if (st == STAT_OK) begin
              ent = pt_mem[l2 * ENTRIES + i2];
              if (ent[BIT_PRESENT] && ent[BIT_LARGE]) begin
                r64 = (ent & MASK52 & ~OFF_2M) | (va64 & OFF_2M);
              end else begin
                st = follow_link(l2, i2, 1'b0, l1);
                if (st == STAT_OK) begin
                  ent = pt_mem[l1 * ENTRIES + i1];
                  if (ent[BIT_PRESENT]) r64 = (ent & ADDR_MASK) | (va64 & OFF_4K);
                  else st = STAT_MISSING;
                end
              end
            end
          end
        end
      end
      default: begin
        // Unknown command: no walk, zero result.
      end
    endcase
    if (st != STAT_OK) r64 = '0;
    res = r64[51:0];
  endfunction

  function automatic bit [47:0] make_va(input bit [8:0] i4, input bit [8:0] i3,
                                        input bit [8:0] i2, input bit [8:0] i1,
                                        input bit [11:0] off);
    return {i4, i3, i2, i1, off};
  endfunction

  // Draw from a few index values per level so walks share tables.
  function automatic bit [8:0] hot_index(input int unsigned level);
    case ($urandom_range(2))
      0: return 9'd0;
      1: return 9'd511;
      default: return (level == 0) ? 9'd7 : 9'(level * 97);
    endcase
  endfunction

  // Driver: present a word at the falling edge, hold it until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_valid <= 1'b1;
        s_data  <= {pending_cmds[0].flags, pending_cmds[0].pa, pending_cmds[0].va};
        s_user  <= pending_cmds[0].cmd;
        void'(pending_cmds.pop_front());
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off to fill the block.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 100) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: predict on every accepted command, check every accepted result.
  always @(posedge clk_i) begin : watch
    walk_result_t want;
    bit [51:0] exp_addr;
    status_e exp_st;
    if (rst_ni) begin
      in_taken <= s_valid && s_axis_tready_o;
      if (s_valid && s_axis_tready_o) begin
        predict_walk(s_user, s_data[47:0], s_data[99:48], s_data[111:100], exp_addr, exp_st);
        want.addr = exp_addr;
        want.status = exp_st;
        expected_results.push_back(want);
        words_taken++;
        cmd_seen[s_user]++;
        outcome_seen[int'(exp_st)]++;
      end
      if (m_axis_tvalid_o && m_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", m_axis_tdata_o));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_o[51:0] !== want.addr)
            report_mismatch($sformatf("result %0d: result_addr %h, want %h",
                                      results_seen, m_axis_tdata_o[51:0], want.addr));
          if (m_axis_tdata_o[54:52] !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                      results_seen, m_axis_tdata_o[54:52], want.status));
        end
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input bit [47:0] va,
                           input bit [51:0] pa, input bit [11:0] flags);
    walk_cmd_t c;
    c.cmd = cmd;
    c.va = va;
    c.pa = pa;
    c.flags = flags;
    pending_cmds.push_back(c);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // Drain, write the pool base, then switch the idling mix.
  task automatic start_phase(input bit [51:0] base, input int unsigned s_idle,
                             input int unsigned r_idle);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_base = base;
    base_settings++;
    send_idle = s_idle;
    recv_idle = r_idle;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly walks over shared paths; some fully random addresses as noise.
  task automatic queue_random(input int unsigned n);
    int unsigned counted, roll;
    logic [1:0] cmd;
    bit [47:0] va;
    bit [63:0] r64;
    bit [51:0] pa;
    bit [11:0] flags;
    bit [8:0] leaf_idx;
    counted = 0;
    while (counted < n) begin
      roll = $urandom_range(99);
      if (roll < 42) cmd = CMD_MAP;
      else if (roll < 75) cmd = CMD_TRANSLATE;
      else if (roll < 96) cmd = CMD_UNMAP;
      else cmd = 2'd3;
      r64 = {$urandom, $urandom};
      if ($urandom_range(99) < 15) begin
        va = r64[47:0];
      end else begin
        leaf_idx = ($urandom_range(99) < 70) ? hot_index(3) : 9'($urandom);
        va = make_va(hot_index(0), hot_index(1), hot_index(2), leaf_idx, 12'($urandom));
      end
      r64 = {$urandom, $urandom};
      pa = r64[51:0];
      roll = $urandom_range(99);
      if (roll < 30) pa[29:0] = '0;
      else if (roll < 60) pa[20:0] = '0;
      flags = 12'($urandom);
      if ($urandom_range(1) == 1) flags[BIT_LARGE] = 1'b1;
      if ($urandom_range(99) < 85) flags[BIT_PRESENT] = 1'b1;
      queue_cmd(cmd, va, pa, flags);
      if (cmd != 2'd3) counted++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walks, base at zero.
    start_phase(52'd0, 26, 71);
    queue_cmd(CMD_TRANSLATE, '1, '0, '0);                 // empty root
    queue_cmd(CMD_UNMAP, '0, '0, '0);
    queue_cmd(2'd3, '1, '1, 12'hFFF);                     // unknown command
    queue_cmd(CMD_MAP, '1, '1, 12'hFFF);                  // unaligned large: 4K leaf
    queue_cmd(CMD_TRANSLATE, '1, '0, '0);
    queue_cmd(CMD_UNMAP, '1, '0, '0);
    queue_cmd(CMD_TRANSLATE, '1, '0, '0);                 // leaf cleared
    queue_cmd(CMD_MAP, make_va(0, 1, 0, 0, 0), 52'd10 << 30, 12'h083);
    queue_cmd(CMD_TRANSLATE, make_va(0, 1, 9'h155, 9'h0AA, 12'h123), '0, '0);
    queue_cmd(CMD_MAP, make_va(0, 2, 3, 0, 0), (52'd5 << 30) | (52'd3 << 21), 12'h083);
    queue_cmd(CMD_TRANSLATE, make_va(0, 2, 3, 9'h1FF, 12'hFFF), '0, '0);
    queue_cmd(CMD_MAP, make_va(0, 1, 5, 5, 0), 52'h4000, 12'h003);   // through 1G leaf
    queue_cmd(CMD_UNMAP, make_va(0, 1, 0, 0, 0), '0, '0);
    queue_cmd(CMD_MAP, make_va(0, 2, 4, 0, 0), 52'h1000, 12'h000);   // non-present leaf
    queue_cmd(CMD_TRANSLATE, make_va(0, 2, 4, 0, 0), '0, '0);
    queue_cmd(CMD_UNMAP, make_va(0, 3, 0, 0, 0), '0, '0);

    // Shift the base one page: an old link now points back at the root.
    start_phase(52'h1000, 26, 71);
    queue_cmd(CMD_MAP, make_va(511, 5, 0, 0, 0), 52'd7 << 30, 12'h083);
    queue_cmd(CMD_TRANSLATE, make_va(5, 0, 0, 0, 12'h077), '0, '0);  // large at root
    queue_cmd(CMD_MAP, make_va(5, 0, 0, 0, 0), 52'h2000, 12'h003);

    // Base at the top, low bits set and ignored: old links are bad, new ones wrap.
    start_phase(BASE_TOP | 52'hABC, 26, 71);
    queue_cmd(CMD_TRANSLATE, make_va(0, 1, 0, 0, 0), '0, '0);
    queue_cmd(CMD_MAP, make_va(100, 0, 0, 0, 0), 52'h2000, 12'h003);
    queue_cmd(CMD_TRANSLATE, make_va(100, 0, 0, 0, 0), '0, '0);

    // Random traffic across several base settings and idling mixes.
    start_phase(52'd0, 26, 71);
    queue_random(200);
    start_phase(52'($urandom) | (52'($urandom) << 32), 71, 26);
    queue_random(120);
    start_phase(52'd0, 71, 26);
    queue_random(150);
    start_phase(52'h1000, 0, 0);
    queue_random(80);
    start_phase(52'd0, 0, 0);
    queue_random(100);

    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d commands (%0d map, %0d unmap, %0d translate, %0d unknown) over %0d bases",
             words_taken, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], base_settings);
    $display("Outcomes: ok %0d, missing %0d, pool full %0d, large page %0d, bad reference %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d results still expected", expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
